@@ sv/fee_pkg.sv @@
// ----------------------------------------------------------------------------
// Fire effect frame engine package
// Shared sizes, codes, state type, filter structs, the size clamp and the color palette.
// ----------------------------------------------------------------------------
package fee_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CNT_W      = COL_W + 1;
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int HEAT_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int LINE_DEPTH = 2 * MAX_WIDTH;
   localparam int LINE_W     = COL_W + 1;

   localparam int SIZE_W     = 7;
   localparam int FRAME_W    = 16;
   localparam int HEAT_W     = 8;
   localparam int SUM_W      = HEAT_W + 2;
   localparam int PROD_W     = 2 * SUM_W;
   localparam int MASK_W     = 64;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 2'd2;

   localparam logic ACT_ADVANCE = 1'b0;
   localparam logic ACT_READ    = 1'b1;

   localparam logic [SIZE_W-1:0]  WIDTH_RST  = 7'd64;
   localparam logic [SIZE_W-1:0]  HEIGHT_RST = 7'd64;
   localparam logic [FRAME_W-1:0] LIMIT_RST  = 16'd400;
   localparam logic [FRAME_W-1:0] FRAME_TOP  = 16'hFFFF;

   localparam logic [HEAT_W-1:0] HEAT_FULL = 8'd255;

   // floor(t / 3) == (t * 683) >> 11 for every t below 2048
   localparam logic [PROD_W-1:0] THIRD_MUL   = 20'd683;
   localparam int                THIRD_SHIFT = 11;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_WAIT,
      ST_SEED,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [HEAT_W-1:0] left;
      logic [HEAT_W-1:0] mid;
      logic [HEAT_W-1:0] right;
      logic [HEAT_W-1:0] old;
   } window_type;

   typedef struct packed {
      logic left_edge;
      logic right_edge;
   } edge_type;

   typedef struct packed {
      logic [HEAT_W-1:0] blue;
      logic [HEAT_W-1:0] green;
      logic [HEAT_W-1:0] red;
   } color_type;

   function automatic logic [CNT_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [CNT_W-1:0] maxv);
      logic [CNT_W-1:0] r;
      if (v < SIZE_W'(2))                 r = CNT_W'(2);
      else if (CNT_W'(v) > maxv)          r = maxv;
      else                                r = CNT_W'(v);
      return r;
   endfunction

   function automatic color_type palette(input logic [HEAT_W-1:0] level);
      color_type c;
      logic [2:0] seg;
      logic [4:0] i;
      seg = level[7:5];
      i   = level[4:0];
      c   = '0;
      unique case (seg)
         3'd0: begin
            c.blue = {2'b00, i, 1'b0};
         end
         3'd1: begin
            c.red  = {i, 3'b000};
            c.blue = 8'd64 - {2'b00, i, 1'b0};
         end
         3'd2: begin
            c.red   = HEAT_FULL;
            c.green = {i, 3'b000};
         end
         3'd3: begin
            c.red   = HEAT_FULL;
            c.green = HEAT_FULL;
            c.blue  = {1'b0, i, 2'b00};
         end
         3'd4: begin
            c.red   = HEAT_FULL;
            c.green = HEAT_FULL;
            c.blue  = 8'd64 + {1'b0, i, 2'b00};
         end
         3'd5: begin
            c.red   = HEAT_FULL;
            c.green = HEAT_FULL;
            c.blue  = 8'd128 + {1'b0, i, 2'b00};
         end
         3'd6: begin
            c.red   = HEAT_FULL;
            c.green = HEAT_FULL;
            c.blue  = 8'd192 + {3'b000, i};
         end
         3'd7: begin
            c.red   = HEAT_FULL;
            c.green = HEAT_FULL;
            c.blue  = 8'd224 + {3'b000, i};
         end
      endcase
      return c;
   endfunction

endpackage

@@ sv/fee_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/fee_filter.sv @@
// ----------------------------------------------------------------------------
// Fire cell filter
// Average a cell with its three lower neighbors (two at an edge) and cool it by one step if above one.
// ----------------------------------------------------------------------------
module fee_filter (
   input  fee_pkg::window_type         win,
   input  fee_pkg::edge_type           edges,
   output logic [fee_pkg::HEAT_W-1:0]  heat_new
);

   logic [fee_pkg::SUM_W-1:0]  sum4;
   logic [fee_pkg::SUM_W-1:0]  sum3;
   logic [fee_pkg::PROD_W-1:0] prod;
   logic [fee_pkg::HEAT_W-1:0] avg;

   always_comb begin
      sum4 = fee_pkg::SUM_W'(win.left) + fee_pkg::SUM_W'(win.mid)
           + fee_pkg::SUM_W'(win.right) + fee_pkg::SUM_W'(win.old);
      if (edges.left_edge) begin
         sum3 = fee_pkg::SUM_W'(win.mid) + fee_pkg::SUM_W'(win.right)
              + fee_pkg::SUM_W'(win.old);
      end else begin
         sum3 = fee_pkg::SUM_W'(win.left) + fee_pkg::SUM_W'(win.mid)
              + fee_pkg::SUM_W'(win.old);
      end
      prod = fee_pkg::PROD_W'(sum3) * fee_pkg::THIRD_MUL;
      if (edges.left_edge || edges.right_edge) begin
         avg = fee_pkg::HEAT_W'(prod >> fee_pkg::THIRD_SHIFT);
      end else begin
         avg = sum4[fee_pkg::SUM_W-1:2];
      end
      // cool down anything above one
      if (avg > fee_pkg::HEAT_W'(1)) begin
         heat_new = avg - fee_pkg::HEAT_W'(1);
      end else begin
         heat_new = avg;
      end
   end

endmodule

@@ sv/fire_effect_frame_engine.sv @@
// ----------------------------------------------------------------------------
// Fire effect frame engine
// Heat map in a RAM, swept one cell per cycle from the bottom row up.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  req_    | in  | tdata: spark_mask, read_col, read_row; tuser: action
//  rsp_    | out | tdata: heat, red, green, blue; tuser: burnt_out
//  csr_    | in  | csr_index, csr_wdata (width, height, frame limit)
//
// After reset the heat RAM is cleared, one cell a cycle, with req_tready
// low. A read registers the RAM output in READ_WAIT and the response in
// FINISH. An advance seeds the bottom row, then sweeps the rows above, one
// cell per cycle, set by the single read port of the heat RAM and the line
// buffer. The next request is taken while a response still waits on
// rsp_tready; a finished item holds until the response register frees.
// ----------------------------------------------------------------------------
module fire_effect_frame_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // spark_mask[63:0], read_col[69:64], read_row[75:70], zero fill
   input  logic [fee_pkg::REQ_DATA_W-1:0]    req_tdata,
   // action[0]
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // heat[7:0], red[15:8], green[23:16], blue[31:24]
   output logic [fee_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // burnt_out[0]
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fee_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fee_pkg::FRAME_W-1:0]       csr_wdata
);

   fee_pkg::state_type state_ff, state_in;

   logic [fee_pkg::SIZE_W-1:0]  width_ff;
   logic [fee_pkg::SIZE_W-1:0]  height_ff;
   logic [fee_pkg::FRAME_W-1:0] limit_ff;
   logic [fee_pkg::FRAME_W-1:0] frame_ff;

   logic [fee_pkg::ADDR_W-1:0]  clr_ff;
   logic [fee_pkg::COL_W-1:0]   sx_ff;
   logic [fee_pkg::CNT_W-1:0]   k_ff;
   logic [fee_pkg::ROW_W-1:0]   t_ff;
   logic                        bank_ff;
   logic [fee_pkg::MASK_W-1:0]  spark_ff;
   logic                        end_ff;
   logic                        zero_ff;
   logic                        in_area_ff;
   logic [fee_pkg::HEAT_W-1:0]  pend_heat_ff;
   logic                        pend_burnt_ff;

   logic                        s2_valid_ff;
   logic [fee_pkg::CNT_W-1:0]   s2_k_ff;
   logic [fee_pkg::ROW_W-1:0]   s2_t_ff;
   logic                        s2_bank_ff;
   logic [fee_pkg::HEAT_W-1:0]  b_prev_ff;
   logic [fee_pkg::HEAT_W-1:0]  b_cur_ff;

   logic                        rsp_valid_ff;
   logic [fee_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                        rsp_user_ff;

   logic [fee_pkg::CNT_W-1:0]   w_use;
   logic [fee_pkg::CNT_W-1:0]   h_use;
   logic                        req_acc;
   logic                        rsp_free;
   logic [fee_pkg::COL_W-1:0]   req_col;
   logic [fee_pkg::ROW_W-1:0]   req_row;
   logic [fee_pkg::ROW_W-1:0]   seed_row;
   logic                        seed_bit;
   logic [fee_pkg::COL_W-1:0]   x2;
   logic                        do_write;
   logic                        zero_now;
   logic                        burnt;
   fee_pkg::window_type         win;
   fee_pkg::edge_type           edges;
   fee_pkg::color_type          color;
   logic [fee_pkg::HEAT_W-1:0]  heat_new;

   logic                        heat_we;
   logic [fee_pkg::ADDR_W-1:0]  heat_waddr;
   logic [fee_pkg::HEAT_W-1:0]  heat_wdata;
   logic [fee_pkg::ADDR_W-1:0]  heat_raddr;
   logic [fee_pkg::HEAT_W-1:0]  heat_rdata;
   logic                        line_we;
   logic [fee_pkg::LINE_W-1:0]  line_waddr;
   logic [fee_pkg::HEAT_W-1:0]  line_wdata;
   logic [fee_pkg::LINE_W-1:0]  line_raddr;
   logic [fee_pkg::HEAT_W-1:0]  line_rdata;

   fee_ram #(
      .WIDTH (fee_pkg::HEAT_W),
      .DEPTH (fee_pkg::HEAT_DEPTH)
   ) u_heat_ram (
      .clock   (clock),
      .wr_en   (heat_we),
      .wr_addr (heat_waddr),
      .wr_data (heat_wdata),
      .rd_addr (heat_raddr),
      .rd_data (heat_rdata)
   );

   fee_ram #(
      .WIDTH (fee_pkg::HEAT_W),
      .DEPTH (fee_pkg::LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_waddr),
      .wr_data (line_wdata),
      .rd_addr (line_raddr),
      .rd_data (line_rdata)
   );

   fee_filter u_filter (
      .win      (win),
      .edges    (edges),
      .heat_new (heat_new)
   );

   assign w_use    = fee_pkg::clamp_size(width_ff, fee_pkg::CNT_W'(fee_pkg::MAX_WIDTH));
   assign h_use    = fee_pkg::clamp_size(height_ff, fee_pkg::CNT_W'(fee_pkg::MAX_HEIGHT));
   assign req_acc  = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_col  = req_tdata[fee_pkg::MASK_W +: fee_pkg::COL_W];
   assign req_row  = req_tdata[fee_pkg::MASK_W + fee_pkg::COL_W +: fee_pkg::ROW_W];
   assign seed_row = fee_pkg::ROW_W'(h_use - fee_pkg::CNT_W'(1));
   assign seed_bit = !end_ff && spark_ff[sx_ff];
   assign csr_ready = 1'b1;

   // compute stage: the heat read and line read issued in the cycle before
   assign x2       = fee_pkg::COL_W'(s2_k_ff - fee_pkg::CNT_W'(1));
   assign do_write = s2_valid_ff && (s2_k_ff != '0);
   assign win.left  = b_prev_ff;
   assign win.mid   = b_cur_ff;
   assign win.right = line_rdata;
   assign win.old   = heat_rdata;
   assign edges.left_edge  = (x2 == '0);
   assign edges.right_edge = (s2_k_ff == w_use);
   assign zero_now = zero_ff && !(do_write && (heat_new != '0));
   assign burnt    = end_ff && zero_now;
   assign color    = fee_pkg::palette(pend_heat_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fee_pkg::ST_CLEAR: begin
            if (clr_ff == fee_pkg::ADDR_W'(fee_pkg::HEAT_DEPTH - 1)) begin
               state_in = fee_pkg::ST_IDLE;
            end
         end
         fee_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser[0] == fee_pkg::ACT_READ) state_in = fee_pkg::ST_READ_WAIT;
               else                                    state_in = fee_pkg::ST_SEED;
            end
         end
         fee_pkg::ST_READ_WAIT: begin
            state_in = fee_pkg::ST_FINISH;
         end
         fee_pkg::ST_SEED: begin
            if (fee_pkg::CNT_W'(sx_ff) == w_use - fee_pkg::CNT_W'(1)) begin
               state_in = fee_pkg::ST_SWEEP;
            end
         end
         fee_pkg::ST_SWEEP: begin
            if (k_ff == w_use && t_ff == '0) state_in = fee_pkg::ST_DRAIN;
         end
         fee_pkg::ST_DRAIN: begin
            state_in = fee_pkg::ST_FINISH;
         end
         fee_pkg::ST_FINISH: begin
            if (rsp_free) state_in = fee_pkg::ST_IDLE;
         end
         default: begin
            state_in = fee_pkg::ST_CLEAR;
         end
      endcase
   end

   // memory controls
   always_comb begin
      req_tready = 1'b0;
      heat_we    = 1'b0;
      heat_waddr = {t_ff, sx_ff};
      heat_wdata = '0;
      heat_raddr = {t_ff, fee_pkg::COL_W'(k_ff - fee_pkg::CNT_W'(1))};
      line_we    = 1'b0;
      line_waddr = {!s2_bank_ff, x2};
      line_wdata = heat_new;
      line_raddr = {bank_ff, k_ff[fee_pkg::COL_W-1:0]};
      unique case (state_ff)
         fee_pkg::ST_CLEAR: begin
            heat_we    = 1'b1;
            heat_waddr = clr_ff;
         end
         fee_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            heat_raddr = {req_row, req_col};
         end
         fee_pkg::ST_SEED: begin
            heat_we    = 1'b1;
            heat_waddr = {seed_row, sx_ff};
            heat_wdata = seed_bit ? fee_pkg::HEAT_FULL : '0;
            line_we    = 1'b1;
            line_waddr = {1'b0, sx_ff};
            line_wdata = heat_wdata;
         end
         fee_pkg::ST_SWEEP, fee_pkg::ST_DRAIN: begin
            heat_we    = do_write;
            heat_waddr = {s2_t_ff, x2};
            heat_wdata = heat_new;
            line_we    = do_write;
         end
         fee_pkg::ST_READ_WAIT, fee_pkg::ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fee_pkg::ST_CLEAR;
         width_ff      <= fee_pkg::WIDTH_RST;
         height_ff     <= fee_pkg::HEIGHT_RST;
         limit_ff      <= fee_pkg::LIMIT_RST;
         frame_ff      <= '0;
         clr_ff        <= '0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s2_valid_ff <= (state_ff == fee_pkg::ST_SWEEP);

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               fee_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[fee_pkg::SIZE_W-1:0];
               fee_pkg::CSR_HEIGHT: height_ff <= csr_wdata[fee_pkg::SIZE_W-1:0];
               fee_pkg::CSR_LIMIT:  limit_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (state_ff == fee_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + fee_pkg::ADDR_W'(1);
         end

         if (state_ff == fee_pkg::ST_DRAIN) begin
            if (burnt) begin
               frame_ff <= '0;
            end else if (frame_ff != fee_pkg::FRAME_TOP) begin
               frame_ff <= frame_ff + fee_pkg::FRAME_W'(1);
            end
         end

         if (state_ff == fee_pkg::ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      s2_k_ff    <= k_ff;
      s2_t_ff    <= t_ff;
      s2_bank_ff <= bank_ff;
      if (s2_valid_ff) begin
         b_prev_ff <= b_cur_ff;
         b_cur_ff  <= line_rdata;
      end

      unique case (state_ff)
         fee_pkg::ST_IDLE: begin
            spark_ff     <= req_tdata[fee_pkg::MASK_W-1:0];
            end_ff       <= (frame_ff >= limit_ff);
            zero_ff      <= 1'b1;
            sx_ff        <= '0;
            pend_heat_ff <= '0;
            pend_burnt_ff <= 1'b0;
            in_area_ff   <= (fee_pkg::CNT_W'(req_col) < w_use)
                         && (fee_pkg::CNT_W'(req_row) < h_use);
         end
         fee_pkg::ST_READ_WAIT: begin
            pend_heat_ff <= in_area_ff ? heat_rdata : '0;
         end
         fee_pkg::ST_SEED: begin
            sx_ff   <= sx_ff + fee_pkg::COL_W'(1);
            if (seed_bit) zero_ff <= 1'b0;
            k_ff    <= '0;
            t_ff    <= fee_pkg::ROW_W'(h_use - fee_pkg::CNT_W'(2));
            bank_ff <= 1'b0;
         end
         fee_pkg::ST_SWEEP: begin
            zero_ff <= zero_now;
            if (k_ff == w_use) begin
               k_ff    <= '0;
               t_ff    <= t_ff - fee_pkg::ROW_W'(1);
               bank_ff <= !bank_ff;
            end else begin
               k_ff <= k_ff + fee_pkg::CNT_W'(1);
            end
         end
         fee_pkg::ST_DRAIN: begin
            zero_ff       <= zero_now;
            pend_burnt_ff <= burnt;
         end
         fee_pkg::ST_CLEAR, fee_pkg::ST_FINISH: begin
         end
         default: begin
         end
      endcase

      if (state_ff == fee_pkg::ST_FINISH && rsp_free) begin
         rsp_data_ff <= {color.blue, color.green, color.red, pend_heat_ff};
         rsp_user_ff <= pend_burnt_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
